@@ src/smf_pkg.sv @@
// Shared types and constants of the sliding median filter.
// No dependencies; used by smf_ctrl, smf_datapath and the top level.
package smf_pkg;

    localparam int SAMPLE_W   = 32;
    localparam int HALF_W     = 3;
    localparam int LEN_W      = 13;
    localparam int POS_W      = 12;
    localparam int CFG_W      = LEN_W;
    localparam int MAX_HALF   = 7;
    localparam int MAX_LINE   = 4096;
    localparam int RING_DEPTH = 2 * MAX_HALF + 1;
    localparam int TAP_W      = $clog2(RING_DEPTH);
    localparam int RANK_W     = $clog2(RING_DEPTH);

    // register indexes of the configuration port
    localparam logic CFG_HALF_WIDTH  = 1'b0;
    localparam logic CFG_LINE_LENGTH = 1'b1;

    typedef logic [SAMPLE_W-1:0] t_sample;

    // controller to datapath commands
    typedef struct packed {
        logic              shift;     // take the accepted word into the tap line
        logic              med_start; // restart the rank search
        logic              med_step;  // test one candidate
        logic              load;      // load the output register
        logic              sel_med;   // output source: found median, else a tap
        logic [TAP_W-1:0]  tap_idx;   // tap to output
        logic              line_end;
        logic [HALF_W-1:0] half;      // effective half width
    } t_dp_cmd;

    // datapath to controller status
    typedef struct packed {
        logic out_free;
        logic med_found;
    } t_dp_sts;

endpackage

@@ src/sliding_median_filter_top.sv @@
// Sliding median filter, top level: joins controller and datapath (smf_pkg, smf_ctrl, smf_datapath).
// Results: a raw word goes from the emit state into the output register; a median first passes the
// rank search, which tests k = 1 .. 2h+1 candidates, one per cycle, before the emit state.
// Flow: input is ready only while idle; a word that gives nothing keeps it idle, else the next word
// waits for its results to load, plus h right-edge words after a line's last; a stalled output holds.
// Reset (synchronous, active low) clears state, position and output valid; half_width 1, length 4096.
module sliding_median_filter_top (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // configuration port: index 0 half_width, index 1 line_length
    input  logic                        i_cfg_wr_en,
    input  logic                        i_cfg_index,
    input  logic [smf_pkg::CFG_W-1:0]   i_cfg_wr_data,
    // input words
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic signed [31:0]          i_sample,
    // result words
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic signed [31:0]          o_filtered,
    output logic                        o_line_end
);

    smf_pkg::t_dp_cmd cmd;
    smf_pkg::t_dp_sts sts;
    smf_pkg::t_sample filtered;

    // controller: hold configuration, advance the line position, sequence each word
    smf_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .o_cmd         (cmd),
        .i_sts         (sts)
    );

    // datapath: tap line of the last 15 words, rank search, output register
    smf_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_sample    (smf_pkg::t_sample'(i_sample)),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_filtered  (filtered),
        .o_line_end  (o_line_end)
    );

    assign o_filtered = $signed(filtered);

endmodule

@@ src/smf_datapath.sv @@
// Datapath of the sliding median filter: tap line, rank search and output register.
// Depends on smf_pkg.
module smf_datapath (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  smf_pkg::t_dp_cmd      i_cmd,
    output smf_pkg::t_dp_sts      o_sts,
    input  smf_pkg::t_sample      i_sample,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output smf_pkg::t_sample      o_filtered,
    output logic                  o_line_end
);

    smf_pkg::t_sample                 r_tap [smf_pkg::RING_DEPTH];
    logic [smf_pkg::TAP_W-1:0]        r_cand;
    smf_pkg::t_sample                 r_med;
    logic                             r_out_valid;
    smf_pkg::t_sample                 r_filtered;
    logic                             r_line_end;

    logic [smf_pkg::TAP_W-1:0]        rd_idx;
    smf_pkg::t_sample                 rd_data;
    logic [smf_pkg::RANK_W-1:0]       rank;
    logic                             found;
    logic [smf_pkg::TAP_W:0]          win_last;

    // single read port: candidate during the search, chosen tap otherwise
    assign rd_idx  = i_cmd.med_step ? r_cand : i_cmd.tap_idx;
    assign rd_data = r_tap[rd_idx];
    assign win_last = {smf_pkg::TAP_W'(i_cmd.half), 1'b0};

    // stable rank of the candidate within taps 0 .. 2h
    always_comb begin
        rank = '0;
        for (int j = 0; j < smf_pkg::RING_DEPTH; j++) begin
            if ((smf_pkg::TAP_W+1)'(j) <= win_last) begin
                if ($signed(r_tap[j]) < $signed(rd_data)) begin
                    rank = rank + 1'b1;
                end else if ((r_tap[j] == rd_data) && (smf_pkg::TAP_W'(j) < r_cand)) begin
                    rank = rank + 1'b1;
                end
            end
        end
    end

    assign found = (rank == smf_pkg::RANK_W'(i_cmd.half));

    always_ff @(posedge i_clk) begin
        if (i_cmd.shift) begin
            r_tap[0] <= i_sample;
            for (int k = 1; k < smf_pkg::RING_DEPTH; k++) begin
                r_tap[k] <= r_tap[k-1];
            end
        end
        if (i_cmd.med_start) begin
            r_cand <= '0;
        end else if (i_cmd.med_step) begin
            if (found) begin
                r_med <= rd_data;
            end else begin
                r_cand <= r_cand + 1'b1;
            end
        end
        if (i_cmd.load) begin
            r_filtered <= i_cmd.sel_med ? r_med : rd_data;
            r_line_end <= i_cmd.line_end;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_sts.out_free  = !r_out_valid || i_out_ready;
    assign o_sts.med_found = i_cmd.med_step && found;
    assign o_out_valid     = r_out_valid;
    assign o_filtered      = r_filtered;
    assign o_line_end      = r_line_end;

endmodule

@@ src/smf_ctrl.sv @@
// Controller of the sliding median filter: configuration, line position and sequencing.
// Depends on smf_pkg.
module smf_ctrl (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_wr_en,
    input  logic                         i_cfg_index,
    input  logic [smf_pkg::CFG_W-1:0]    i_cfg_wr_data,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    output smf_pkg::t_dp_cmd             o_cmd,
    input  smf_pkg::t_dp_sts             i_sts
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_MED   = 2'd1;
    localparam logic [1:0] S_EMIT  = 2'd2;
    localparam logic [1:0] S_FLUSH = 2'd3;

    logic [1:0]                   r_state,       n_state;
    logic [smf_pkg::POS_W-1:0]    r_pos,         n_pos;
    logic [smf_pkg::HALF_W-1:0]   r_half_width;
    logic [smf_pkg::LEN_W-1:0]    r_line_length;
    logic [smf_pkg::TAP_W-1:0]    r_emit_idx,    n_emit_idx;
    logic                         r_emit_med,    n_emit_med;
    logic                         r_end_main,    n_end_main;
    logic                         r_flush,       n_flush;
    logic [smf_pkg::HALF_W-1:0]   r_flush_cnt,   n_flush_cnt;

    logic [smf_pkg::HALF_W-1:0]   half;
    logic [smf_pkg::LEN_W-1:0]    len;
    logic [smf_pkg::LEN_W-1:0]    p;
    logic                         last;
    logic                         short_line;
    logic                         accept;

    // clamp the registers to their working ranges
    assign half = (r_half_width == '0) ? smf_pkg::HALF_W'(1) : r_half_width;
    always_comb begin
        if (r_line_length == '0) begin
            len = smf_pkg::LEN_W'(1);
        end else if (r_line_length > smf_pkg::LEN_W'(smf_pkg::MAX_LINE)) begin
            len = smf_pkg::LEN_W'(smf_pkg::MAX_LINE);
        end else begin
            len = r_line_length;
        end
    end

    assign p          = ({1'b0, r_pos} >= len) ? '0 : {1'b0, r_pos};
    assign last       = (p + 1'b1) >= len;
    assign short_line = len < smf_pkg::LEN_W'({half, 1'b1});
    assign accept     = i_in_valid && o_in_ready;
    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state     = r_state;
        n_pos       = r_pos;
        n_emit_idx  = r_emit_idx;
        n_emit_med  = r_emit_med;
        n_end_main  = r_end_main;
        n_flush     = r_flush;
        n_flush_cnt = r_flush_cnt;
        o_cmd       = '0;
        o_cmd.half  = half;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    o_cmd.shift = 1'b1;
                    n_pos       = last ? '0 : smf_pkg::POS_W'(p + 1'b1);
                    n_end_main  = short_line && last;
                    n_flush     = last && !short_line;
                    n_flush_cnt = half;
                    if (short_line) begin
                        n_emit_idx = '0;
                        n_emit_med = 1'b0;
                        n_state    = S_EMIT;
                    end else if (p >= smf_pkg::LEN_W'(half)) begin
                        if (p < smf_pkg::LEN_W'({half, 1'b0})) begin
                            // left edge: the centre sample passes raw
                            n_emit_idx = smf_pkg::TAP_W'(half);
                            n_emit_med = 1'b0;
                            n_state    = S_EMIT;
                        end else begin
                            n_emit_med      = 1'b1;
                            o_cmd.med_start = 1'b1;
                            n_state         = S_MED;
                        end
                    end
                end
            end
            S_MED: begin
                o_cmd.med_step = 1'b1;
                if (i_sts.med_found) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                o_cmd.tap_idx  = r_emit_idx;
                o_cmd.sel_med  = r_emit_med;
                o_cmd.line_end = r_end_main;
                if (i_sts.out_free) begin
                    o_cmd.load = 1'b1;
                    n_state    = r_flush ? S_FLUSH : S_IDLE;
                end
            end
            S_FLUSH: begin
                // right edge: drain the last h samples oldest first
                o_cmd.tap_idx  = smf_pkg::TAP_W'(r_flush_cnt - 1'b1);
                o_cmd.line_end = (r_flush_cnt == smf_pkg::HALF_W'(1));
                if (i_sts.out_free) begin
                    o_cmd.load  = 1'b1;
                    n_flush_cnt = r_flush_cnt - 1'b1;
                    if (r_flush_cnt == smf_pkg::HALF_W'(1)) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        if (i_cfg_wr_en) begin
            n_pos = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_pos         <= '0;
            r_half_width  <= smf_pkg::HALF_W'(1);
            r_line_length <= smf_pkg::LEN_W'(smf_pkg::MAX_LINE);
            r_flush       <= 1'b0;
            r_flush_cnt   <= '0;
        end else begin
            r_state     <= n_state;
            r_pos       <= n_pos;
            r_flush     <= n_flush;
            r_flush_cnt <= n_flush_cnt;
            if (i_cfg_wr_en) begin
                unique case (i_cfg_index)
                    smf_pkg::CFG_HALF_WIDTH:  r_half_width  <= i_cfg_wr_data[smf_pkg::HALF_W-1:0];
                    smf_pkg::CFG_LINE_LENGTH: r_line_length <= i_cfg_wr_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_emit_idx <= n_emit_idx;
        r_emit_med <= n_emit_med;
        r_end_main <= n_end_main;
    end

endmodule

@@ verif/tb_top.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for sliding_median_filter_top: a directed table, then random lines.
// Depends on smf_pkg and the filter RTL; predicts untyped words in-line, checks all in order.
module tb_top;

    localparam int SCRIPT_ROWS   = 25;
    localparam int RANDOM_ITEMS  = 320;
    localparam int SETTLE_CYCLES = 40;    // beyond the longest median search plus right edge drain
    localparam int STALL_LIMIT   = 2000;  // cycles without any handshake before giving up
    localparam int IDLE_PCT      = 36;

    typedef enum logic [1:0] {ROW_SAMPLE, ROW_HALF, ROW_LEN} t_row_kind;

    // one row of the directed table; want/want_end only count where typed is set
    typedef struct packed {
        t_row_kind kind;
        logic [31:0] value;
        logic typed;
        smf_pkg::t_sample want;
        logic want_end;
    } t_row;

    typedef struct packed {
        smf_pkg::t_sample filtered;
        logic line_end;
    } t_result;

    localparam t_row SCRIPT [SCRIPT_ROWS] = '{
        // after reset: half width 1, line of 4096; left edge raw, then a plain median
        '{ROW_SAMPLE, 32'h7FFF_FFFF, 1'b0, 32'h0, 1'b0},
        '{ROW_SAMPLE, 32'h8000_0000, 1'b1, 32'h7FFF_FFFF, 1'b0},
        '{ROW_SAMPLE, 32'h0000_0000, 1'b1, 32'h0000_0000, 1'b0},
        // one-sample lines: every word passes straight through and ends its line
        '{ROW_LEN, 32'd1, 1'b0, 32'h0, 1'b0},
        '{ROW_SAMPLE, 32'h8000_0000, 1'b1, 32'h8000_0000, 1'b1},
        '{ROW_SAMPLE, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF, 1'b1},
        // zero length behaves as one
        '{ROW_LEN, 32'd0, 1'b0, 32'h0, 1'b0},
        '{ROW_SAMPLE, 32'h1234_5678, 1'b1, 32'h1234_5678, 1'b1},
        // zero half width behaves as one; a line exactly one window long
        '{ROW_HALF, 32'd0, 1'b0, 32'h0, 1'b0},
        '{ROW_LEN, 32'd3, 1'b0, 32'h0, 1'b0},
        '{ROW_SAMPLE, 32'h0001_0000, 1'b0, 32'h0, 1'b0},
        '{ROW_SAMPLE, 32'hFFFF_0000, 1'b1, 32'h0001_0000, 1'b0},
        '{ROW_SAMPLE, 32'h0000_8000, 1'b0, 32'h0, 1'b0},
        // widest window on a line shorter than it: raw pass-through
        '{ROW_HALF, 32'd7, 1'b0, 32'h0, 1'b0},
        '{ROW_LEN, 32'd2, 1'b0, 32'h0, 1'b0},
        '{ROW_SAMPLE, 32'h5555_5555, 1'b1, 32'h5555_5555, 1'b0},
        '{ROW_SAMPLE, 32'hAAAA_AAAA, 1'b1, 32'hAAAA_AAAA, 1'b1},
        // oversized length saturates; left edge of a window of nine
        '{ROW_HALF, 32'd4, 1'b0, 32'h0, 1'b0},
        '{ROW_LEN, 32'd8191, 1'b0, 32'h0, 1'b0},
        '{ROW_SAMPLE, 32'h7FFF_FFFF, 1'b0, 32'h0, 1'b0},
        '{ROW_SAMPLE, 32'h8000_0000, 1'b0, 32'h0, 1'b0},
        '{ROW_SAMPLE, 32'h0000_0001, 1'b0, 32'h0, 1'b0},
        '{ROW_SAMPLE, 32'hFFFF_FFFF, 1'b0, 32'h0, 1'b0},
        '{ROW_SAMPLE, 32'h7FFF_FFFF, 1'b1, 32'h7FFF_FFFF, 1'b0},
        '{ROW_SAMPLE, 32'h0000_0000, 1'b1, 32'h8000_0000, 1'b0}
    };

    // stimulus side of the block
    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_wr_en = 1'b0;
    logic i_cfg_index = smf_pkg::CFG_HALF_WIDTH;
    logic [smf_pkg::CFG_W-1:0] i_cfg_wr_data = '0;
    logic i_in_valid = 1'b0;
    logic signed [31:0] i_sample = '0;
    logic i_out_ready = 1'b0;
    logic o_in_ready;
    logic o_out_valid;
    logic signed [31:0] o_filtered;
    logic o_line_end;

    // predictor state: a copy of the line ring, position and both registers
    smf_pkg::t_sample line_ring [smf_pkg::RING_DEPTH];
    int unsigned line_pos = 0;
    logic [smf_pkg::HALF_W-1:0] cur_half = 3'd1;
    logic [smf_pkg::LEN_W-1:0] cur_len = 13'd4096;

    t_result step_words [$];   // words caused by the most recent sample
    t_result filtered_due [$]; // words still to come out of the block, oldest first
    int unsigned mismatches = 0;
    int unsigned stall_cycles = 0;
    bit steady = 1'b0;         // set for the stretch with no idling on either side

    sliding_median_filter_top u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_sample      (i_sample),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_filtered    (o_filtered),
        .o_line_end    (o_line_end)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic int unsigned half_eff();
        if (cur_half == 0) return 1;
        if (cur_half > smf_pkg::MAX_HALF) return smf_pkg::MAX_HALF;
        return 32'(cur_half);
    endfunction

    function automatic int unsigned len_eff();
        if (cur_len == 0) return 1;
        if (cur_len > smf_pkg::MAX_LINE) return smf_pkg::MAX_LINE;
        return 32'(cur_len);
    endfunction

    // (h+1)-th smallest, signed, of the 2h+1 words ending at position last
    function automatic smf_pkg::t_sample window_median(input int unsigned last,
                                                       input int unsigned h);
        logic signed [smf_pkg::SAMPLE_W-1:0] keys [smf_pkg::RING_DEPTH];
        logic signed [smf_pkg::SAMPLE_W-1:0] v;
        int i;
        int j;
        for (i = 0; i < 2 * h + 1; i++)
            keys[i] = line_ring[(last - 2 * h + i) % smf_pkg::RING_DEPTH];
        for (i = 1; i < 2 * h + 1; i++) begin
            v = keys[i];
            j = i;
            while (j > 0 && keys[j - 1] > v) begin
                keys[j] = keys[j - 1];
                j--;
            end
            keys[j] = v;
        end
        return keys[h];
    endfunction

    // advance the predictor by one accepted word; leaves its results in step_words
    function automatic void filter_sample(input smf_pkg::t_sample s);
        int unsigned h;
        int unsigned len;
        int unsigned p;
        int unsigned q;
        logic last;
        h = half_eff();
        len = len_eff();
        p = line_pos;
        if (p >= len) p = 0;
        last = (p + 1 >= len);
        line_ring[p % smf_pkg::RING_DEPTH] = s;
        step_words.delete();
        if (len < 2 * h + 1) begin
            // short line: everything passes through at once
            step_words.push_back(t_result'{s, last});
        end else begin
            if (p >= h) begin
                q = p - h;
                if (q < h)
                    step_words.push_back(t_result'{line_ring[q % smf_pkg::RING_DEPTH], 1'b0});
                else
                    step_words.push_back(t_result'{window_median(p, h), 1'b0});
            end
            // the last word flushes the right edge raw
            if (last)
                for (q = len - h; q < len; q++)
                    step_words.push_back(t_result'{line_ring[q % smf_pkg::RING_DEPTH],
                                                   q + 1 == len});
        end
        line_pos = last ? 0 : p + 1;
    endfunction

    function automatic void flag_mismatch(input string what);
        mismatches++;
        if (mismatches <= 10) $display("mismatch: %s", what);
    endfunction

    // write one register; the line restarts in the predictor too
    task automatic write_reg(input logic idx, input logic [smf_pkg::CFG_W-1:0] data);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wr_data <= data;
        @(posedge i_clk);
        if (idx == smf_pkg::CFG_HALF_WIDTH) cur_half = data[smf_pkg::HALF_W-1:0];
        else cur_len = data;
        line_pos = 0;
    endtask

    // hold the input until every expected word is out and the block has gone quiet
    task automatic settle();
        i_cfg_wr_en <= 1'b0;
        i_in_valid <= 1'b0;
        while (filtered_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // offer one word, with random idle cycles first, and predict once it is taken
    task automatic push_sample(input smf_pkg::t_sample s, input logic typed,
                               input t_result want);
        i_cfg_wr_en <= 1'b0;
        while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_sample <= s;
        do @(posedge i_clk); while (!o_in_ready);
        filter_sample(s);
        if (typed) begin
            filtered_due.push_back(want);
        end else begin
            foreach (step_words[i]) filtered_due.push_back(step_words[i]);
        end
    endtask

    // mostly full-range words, with extremes and a narrow band to force ties
    function automatic smf_pkg::t_sample pick_sample();
        case ($urandom_range(0, 7))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2, 3: return 32'($urandom_range(0, 4)) - 32'd2;
            default: return $urandom();
        endcase
    endfunction

    // receiver: drop ready at random except during the steady stretch
    always @(posedge i_clk)
        i_out_ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);

    // check every word taken from the block against the oldest prediction
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (filtered_due.size() == 0) begin
                flag_mismatch($sformatf("unexpected word filtered %h line_end %0b",
                                        o_filtered, o_line_end));
            end else begin
                want = filtered_due.pop_front();
                if (o_filtered !== want.filtered || o_line_end !== want.line_end)
                    flag_mismatch($sformatf("filtered %h line_end %0b, expected %h line_end %0b",
                                            o_filtered, o_line_end, want.filtered,
                                            want.line_end));
            end
        end
    end

    // watchdog: give up once no word has moved on either side for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles == STALL_LIMIT) begin
            $display("FAILURE");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        int r;
        int unsigned sent;
        int unsigned phase;
        int unsigned n;
        int unsigned k;
        int unsigned eff;
        logic [smf_pkg::HALF_W-1:0] half;
        logic [smf_pkg::CFG_W-1:0] len;
        logic [smf_pkg::CFG_W-1:0] half_word;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed table
        for (r = 0; r < SCRIPT_ROWS; r++) begin
            case (SCRIPT[r].kind)
                ROW_HALF: begin
                    settle();
                    write_reg(smf_pkg::CFG_HALF_WIDTH, SCRIPT[r].value[smf_pkg::CFG_W-1:0]);
                end
                ROW_LEN: begin
                    settle();
                    write_reg(smf_pkg::CFG_LINE_LENGTH, SCRIPT[r].value[smf_pkg::CFG_W-1:0]);
                end
                default: push_sample(SCRIPT[r].value, SCRIPT[r].typed,
                                     t_result'{SCRIPT[r].want, SCRIPT[r].want_end});
            endcase
        end

        // random lines: a fresh setting per phase; lines up to 64 long get whole lines plus a ragged tail
        sent = 0;
        phase = 0;
        while (sent < RANDOM_ITEMS) begin
            settle();
            half = (phase == 0) ? 3'd7 : (phase == 1) ? 3'd0
                                       : 3'($urandom_range(0, smf_pkg::MAX_HALF));
            case (phase)
                0: len = smf_pkg::CFG_W'(2 * smf_pkg::MAX_HALF + 1);
                1: len = '1;
                2: len = smf_pkg::CFG_W'(smf_pkg::MAX_LINE);
                default: begin
                    case ($urandom_range(0, 9))
                        0: len = smf_pkg::CFG_W'($urandom_range(0, 2));
                        1: len = smf_pkg::CFG_W'($urandom_range(smf_pkg::MAX_LINE, 8191));
                        default: len = smf_pkg::CFG_W'($urandom_range(1, 32));
                    endcase
                end
            endcase
            // upper bits of the half width word are junk the register must ignore
            half_word = {10'($urandom_range(0, 1023)), half};
            if ($urandom_range(0, 1)) begin
                write_reg(smf_pkg::CFG_HALF_WIDTH, half_word);
                write_reg(smf_pkg::CFG_LINE_LENGTH, len);
            end else begin
                write_reg(smf_pkg::CFG_LINE_LENGTH, len);
                write_reg(smf_pkg::CFG_HALF_WIDTH, half_word);
            end
            steady <= (phase == 3 || phase == 4);
            eff = len_eff();
            if (eff > 64) n = $urandom_range(20, 40);
            else n = eff * $urandom_range(1, 4) + $urandom_range(0, 2);
            for (k = 0; k < n; k++) begin
                // halfway through one phase, pause until everything is out
                if (phase == 2 && k == n / 2) settle();
                push_sample(pick_sample(), 1'b0, t_result'{32'h0, 1'b0});
            end
            sent += n;
            phase++;
        end

        steady <= 1'b0;
        settle();
        if (mismatches == 0 && filtered_due.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
